>>> hw/rtl/fhd_pkg.sv
// Shared types and constants of the frame header decoder.
package fhd_pkg;

  localparam int unsigned HdrBytes = 16;
  localparam int unsigned HdrBits  = 8 * HdrBytes;
  localparam int unsigned PosW     = $clog2(HdrBytes);

  // Byte offsets of the header fields, big-endian.
  localparam int unsigned OffMagic = 0;
  localparam int unsigned OffLen   = 2;
  localparam int unsigned OffId    = 6;
  localparam int unsigned OffFlags = 10;
  localparam int unsigned OffSeq   = 12;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 32;

  localparam logic [15:0] MagicReset      = 16'h0000;
  localparam logic [31:0] MaxPayloadReset = 32'd65535;

  typedef enum logic [CfgIdxW-1:0] {
    REG_EXPECTED_MAGIC = 1'b0,
    REG_MAX_PAYLOAD    = 1'b1
  } fhd_reg_e;

  typedef enum logic [1:0] {
    KIND_HEADER     = 2'd0,
    KIND_PAYLOAD    = 2'd1,
    KIND_BAD_MAGIC  = 2'd2,
    KIND_OVER_LIMIT = 2'd3
  } fhd_kind_e;

  typedef struct packed {
    fhd_kind_e   kind;
    logic [31:0] msg_id;
    logic [15:0] flag_bits;
    logic [31:0] seq_num;
    logic [31:0] payload_len;
    logic [7:0]  data_byte;
    logic        last;
  } fhd_res_t;

  typedef struct packed {
    logic [15:0] expected_magic;
    logic [31:0] max_payload;
  } fhd_cfg_t;

endpackage

>>> hw/rtl/fhd_parse.sv
// Input register, frame state and single-pass header/payload decode.
module fhd_parse (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fhd_pkg::fhd_cfg_t cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       byte_in_i,
  input  logic             res_free_i,
  output logic             res_valid_o,
  output fhd_pkg::fhd_res_t res_o
);
  import fhd_pkg::*;

  localparam logic [PosW-1:0] LastPos = PosW'(HdrBytes - 1);

  logic                 in_valid_q, in_valid_d;
  logic [7:0]           in_byte_q;
  logic                 in_payload_q, in_payload_d;
  logic [PosW-1:0]      hdr_pos_q, hdr_pos_d;
  logic [HdrBits-9:0]   hdr_q, hdr_d;
  logic [31:0]          bytes_rem_q, bytes_rem_d;

  logic                 hdr_done;
  logic                 produces;
  logic                 advance;
  logic [HdrBits-1:0]   hdr_full;
  logic [15:0]          magic;
  logic [31:0]          len;
  logic [31:0]          rem_dec;

  assign hdr_done = !in_payload_q && (hdr_pos_q == LastPos);
  assign produces = in_payload_q || hdr_done;
  // A word that gives no result never waits on the output side.
  assign advance  = in_valid_q && (!produces || res_free_i);
  assign in_ready_o = !in_valid_q || advance;

  assign hdr_full = {hdr_q, in_byte_q};
  assign magic    = hdr_full[HdrBits - 1 - 8*OffMagic -: 16];
  assign len      = hdr_full[HdrBits - 1 - 8*OffLen   -: 32];
  assign rem_dec  = bytes_rem_q - 32'd1;

  always_comb begin
    res_o        = '0;
    res_o.kind   = KIND_HEADER;
    in_payload_d = in_payload_q;
    hdr_pos_d    = hdr_pos_q;
    hdr_d        = hdr_q;
    bytes_rem_d  = bytes_rem_q;
    if (in_payload_q) begin
      res_o.kind      = KIND_PAYLOAD;
      res_o.data_byte = in_byte_q;
      res_o.last      = (rem_dec == '0);
      bytes_rem_d     = rem_dec;
      in_payload_d    = (rem_dec != '0);
    end else if (hdr_done) begin
      hdr_pos_d  = '0;
      res_o.last = 1'b1;
      priority if (magic != cfg_i.expected_magic) begin
        res_o.kind = KIND_BAD_MAGIC;
      end else if (len > cfg_i.max_payload) begin
        res_o.kind = KIND_OVER_LIMIT;
      end else begin
        res_o.kind        = KIND_HEADER;
        res_o.msg_id      = hdr_full[HdrBits - 1 - 8*OffId    -: 32];
        res_o.flag_bits   = hdr_full[HdrBits - 1 - 8*OffFlags -: 16];
        res_o.seq_num     = hdr_full[HdrBits - 1 - 8*OffSeq   -: 32];
        res_o.payload_len = len;
        res_o.last        = (len == '0);
        in_payload_d      = (len != '0);
        bytes_rem_d       = len;
      end
    end else begin
      // Header bytes enter from the low end, so byte 0 ends up on top.
      hdr_d     = {hdr_q[HdrBits-17:0], in_byte_q};
      hdr_pos_d = hdr_pos_q + PosW'(1);
    end
  end

  assign res_valid_o = advance && produces;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_ready_o) begin
      in_valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      in_payload_q <= 1'b0;
      hdr_pos_q    <= '0;
      bytes_rem_q  <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      if (advance) begin
        in_payload_q <= in_payload_d;
        hdr_pos_q    <= hdr_pos_d;
        bytes_rem_q  <= bytes_rem_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= byte_in_i;
    end
    if (advance) begin
      hdr_q <= hdr_d;
    end
  end

  a_payload_pos_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_payload_q |-> hdr_pos_q == '0)
    else $error("header position not cleared during payload");

  a_payload_rem_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_payload_q |-> bytes_rem_q != '0)
    else $error("payload phase with no bytes remaining");

  a_no_early_payload : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !in_payload_q && hdr_pos_q != LastPos) |=> !in_payload_q)
    else $error("payload phase entered before header complete");

  a_result_only_when_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_free_i)
    else $error("result produced while output register busy");

endmodule

>>> hw/rtl/fhd_out_reg.sv
// Result register toward the output channel.
module fhd_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  fhd_pkg::fhd_res_t res_i,
  output logic              res_free_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fhd_pkg::fhd_res_t out_o
);
  import fhd_pkg::*;

  logic     out_valid_q, out_valid_d;
  fhd_res_t out_q;

  // The register can take a new word when empty or when its word leaves now.
  assign res_free_o = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid_i) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      out_q <= res_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

>>> hw/rtl/frame_header_decoder.sv
// Top level of the length-prefixed frame header decoder.
// Usage:
//   The input channel (in_valid_i, in_ready_o, byte_in_i) carries one stream
//   byte per word. The block collects a 16-byte big-endian header, checks the
//   magic against expected_magic and then the length against max_payload,
//   and emits one header or error word on the output channel. Payload bytes
//   then pass through one word each, and the final word of a frame has
//   last_o set. Header bytes other than the sixteenth give no output word.
//   Configuration: cfg_we_i writes register cfg_idx_i (0 expected magic,
//   1 maximum payload) from cfg_data_i on the same edge; write only when idle.
//   Pipeline: a byte waits in the input register and any word it yields in the
//   result register; throughput is one byte per cycle unless the receiver stalls.
//   The two registers form a two-stage pipeline with one decode pass between.
//   Reset: header collection starts at byte 0, expected magic is 0 and the
//   payload limit is 65535. When the receiver stalls, the result register
//   holds its word and one more byte can sit in the input register; header
//   bytes that give no result keep flowing into the header store.
module frame_header_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [fhd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fhd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  kind_o,
  output logic [31:0] msg_id_o,
  output logic [15:0] flag_bits_o,
  output logic [31:0] seq_num_o,
  output logic [31:0] payload_len_o,
  output logic [7:0]  data_byte_o,
  output logic        last_o
);
  import fhd_pkg::*;

  fhd_cfg_t cfg_q;
  fhd_res_t res;
  fhd_res_t out;
  logic     res_valid;
  logic     res_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_magic <= MagicReset;
      cfg_q.max_payload    <= MaxPayloadReset;
    end else if (cfg_we_i) begin
      unique case (fhd_reg_e'(cfg_idx_i))
        REG_EXPECTED_MAGIC: cfg_q.expected_magic <= cfg_data_i[15:0];
        REG_MAX_PAYLOAD:    cfg_q.max_payload    <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  fhd_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .byte_in_i   (byte_in_i),
    .res_free_i  (res_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  fhd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_free_o  (res_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out)
  );

  assign kind_o        = out.kind;
  assign msg_id_o      = out.msg_id;
  assign flag_bits_o   = out.flag_bits;
  assign seq_num_o     = out.seq_num;
  assign payload_len_o = out.payload_len;
  assign data_byte_o   = out.data_byte;
  assign last_o        = out.last;

endmodule

>>> test/frame_header_decoder_chk.sv
// Checker for the frame header decoder: predicts each output word and compares it.
module frame_header_decoder_chk (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fhd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fhd_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [7:0]                   byte_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [1:0]                   kind_i,
  input  logic [31:0]                  msg_id_i,
  input  logic [15:0]                  flag_bits_i,
  input  logic [31:0]                  seq_num_i,
  input  logic [31:0]                  payload_len_i,
  input  logic [7:0]                   data_byte_i,
  input  logic                         last_i,
  output int unsigned                  mismatches_o,
  output int unsigned                  pending_o,
  output logic                         aligned_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import fhd_pkg::*;

  logic [15:0]     magic_want;
  logic [31:0]     len_limit;
  logic            in_body;
  logic [PosW-1:0] hdr_pos;
  logic [7:0]      hdr_store [HdrBytes];
  logic [31:0]     body_left;

  fhd_res_t decoded_q[$];
  fhd_res_t want_res;
  fhd_res_t got_res;
  fhd_res_t new_res;

  function automatic logic [15:0] hdr_half(int unsigned off);
    return {hdr_store[off], hdr_store[off+1]};
  endfunction

  function automatic logic [31:0] hdr_word(int unsigned off);
    return {hdr_store[off], hdr_store[off+1], hdr_store[off+2], hdr_store[off+3]};
  endfunction

  // Advances the frame state by one stream byte; returns 1 when the byte yields a word.
  function automatic bit decode_byte(input logic [7:0] b, output fhd_res_t res);
    logic [31:0] len;
    res = '0;
    if (in_body) begin
      body_left = body_left - 32'd1;
      in_body   = (body_left != 0);
      res.kind      = KIND_PAYLOAD;
      res.data_byte = b;
      res.last      = !in_body;
      return 1'b1;
    end
    hdr_store[hdr_pos] = b;
    if (hdr_pos != PosW'(HdrBytes - 1)) begin
      hdr_pos = hdr_pos + PosW'(1);
      return 1'b0;
    end
    hdr_pos  = '0;
    len      = hdr_word(OffLen);
    res.last = 1'b1;
    // The magic is checked first, so a bad magic hides an oversized length.
    if (hdr_half(OffMagic) != magic_want) begin
      res.kind = KIND_BAD_MAGIC;
    end else if (len > len_limit) begin
      res.kind = KIND_OVER_LIMIT;
    end else begin
      res.kind        = KIND_HEADER;
      res.msg_id      = hdr_word(OffId);
      res.flag_bits   = hdr_half(OffFlags);
      res.seq_num     = hdr_word(OffSeq);
      res.payload_len = len;
      res.last        = (len == 0);
      in_body         = (len != 0);
      body_left       = len;
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_want = MagicReset;
      len_limit  = MaxPayloadReset;
      in_body    = 1'b0;
      hdr_pos    = '0;
      body_left  = '0;
      decoded_q.delete();
      aligned_o <= 1'b1;
      pending_o <= 0;
    end else begin
      // Output side first: a word can never leave on the edge its byte enters.
      if (out_valid_i && out_ready_i) begin
        got_res.kind        = fhd_kind_e'(kind_i);
        got_res.msg_id      = msg_id_i;
        got_res.flag_bits   = flag_bits_i;
        got_res.seq_num     = seq_num_i;
        got_res.payload_len = payload_len_i;
        got_res.data_byte   = data_byte_i;
        got_res.last        = last_i;
        if (decoded_q.size() == 0) begin
          mismatches_o++;
          $display("%0t: unexpected word kind=%0d data=%h last=%b",
                   $time, kind_i, data_byte_i, last_i);
        end else begin
          want_res = decoded_q.pop_front();
          if (got_res !== want_res) begin
            mismatches_o++;
            $display("%0t: expected kind=%0d id=%h flags=%h seq=%h len=%h data=%h last=%b",
                     $time, want_res.kind, want_res.msg_id, want_res.flag_bits,
                     want_res.seq_num, want_res.payload_len, want_res.data_byte,
                     want_res.last);
            $display("%0t: actual   kind=%0d id=%h flags=%h seq=%h len=%h data=%h last=%b",
                     $time, kind_i, msg_id_i, flag_bits_i, seq_num_i, payload_len_i,
                     data_byte_i, last_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (decode_byte(byte_i, new_res)) begin
          decoded_q = {decoded_q, new_res};
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_EXPECTED_MAGIC: magic_want = cfg_data_i[15:0];
          REG_MAX_PAYLOAD:    len_limit  = cfg_data_i;
          default: ;
        endcase
      end
      aligned_o <= !in_body && (hdr_pos == '0);
      pending_o <= decoded_q.size();
    end
  end

endmodule

>>> test/frame_header_decoder_tb.sv
// Testbench top for the frame header decoder: stimulus, stalls and final verdict.
module frame_header_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fhd_pkg::*;

  localparam int unsigned HoldCycles = 300;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic [7:0]          byte_in   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          kind;
  logic [31:0]         msg_id;
  logic [15:0]         flag_bits;
  logic [31:0]         seq_num;
  logic [31:0]         payload_len;
  logic [7:0]          data_byte;
  logic                last;

  int unsigned mismatches;
  int unsigned pending;
  logic        aligned;

  // Values last written to the registers, so the stimulus knows which frames pass.
  logic [15:0] cur_magic = MagicReset;
  logic [31:0] cur_limit = MaxPayloadReset;

  int unsigned bytes_sent  = 0;
  bit          tx_steady   = 1'b0;
  bit          rx_steady   = 1'b0;
  bit          rx_hold_req = 1'b0;

  frame_header_decoder dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .byte_in_i     (byte_in),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .kind_o        (kind),
    .msg_id_o      (msg_id),
    .flag_bits_o   (flag_bits),
    .seq_num_o     (seq_num),
    .payload_len_o (payload_len),
    .data_byte_o   (data_byte),
    .last_o        (last)
  );

  frame_header_decoder_chk chk (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .byte_i        (byte_in),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .kind_i        (kind),
    .msg_id_i      (msg_id),
    .flag_bits_i   (flag_bits),
    .seq_num_i     (seq_num),
    .payload_len_i (payload_len),
    .data_byte_i   (data_byte),
    .last_i        (last),
    .mismatches_o  (mismatches),
    .pending_o     (pending),
    .aligned_o     (aligned)
  );

  always #5 clk = ~clk;

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly short lengths that pass, plus the limit itself when at most 64, one past it and beyond.
  function automatic logic [31:0] pick_len(logic [31:0] lim);
    int unsigned r;
    logic [31:0] cap;
    r   = $urandom_range(0, 99);
    cap = (lim < 24) ? lim : 32'd24;
    if (r < 15) return '0;
    if (r < 65) return (cap == 0) ? '0 : 32'($urandom_range(1, cap));
    if (r < 75 || lim == '1) return (lim <= 64) ? lim : cap;
    if (r < 85) return lim + 32'd1;
    return lim + 32'd1 + ($urandom % (~lim));
  endfunction

  task automatic send_byte(logic [7:0] b);
    int unsigned gap;
    gap = tx_steady ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    byte_in  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Sends a header and, when the decoder will accept it, its payload; cut > 0 stops early.
  task automatic send_frame(logic [15:0] magic, logic [31:0] len, logic [31:0] id,
                            logic [15:0] flags, logic [31:0] seq, int unsigned cut);
    logic [127:0] hdr;
    logic [7:0]   frame_q[$];
    hdr = {magic, len, id, flags, seq};
    for (int i = 0; i < HdrBytes; i++) frame_q = {frame_q, hdr[127-8*i -: 8]};
    if (magic == cur_magic && len <= cur_limit) begin
      repeat (len) frame_q = {frame_q, 8'($urandom)};
    end
    if (cut == 0 || cut > frame_q.size()) cut = frame_q.size();
    for (int i = 0; i < cut; i++) send_byte(frame_q[i]);
  endtask

  // Feeds filler bytes until the decoder sits at a header boundary again.
  task automatic resync();
    in_valid <= 1'b0;
    @(posedge clk);
    while (!aligned) begin
      send_byte(8'($urandom));
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic set_config(logic [15:0] magic, logic [31:0] lim);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // Header bytes give no word, so let the pipeline drain before writing.
    repeat (4) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_EXPECTED_MAGIC;
    cfg_data <= CfgDataW'(magic);
    @(posedge clk);
    cfg_idx  <= REG_MAX_PAYLOAD;
    cfg_data <= lim;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_magic = magic;
    cur_limit = lim;
  endtask

  task automatic run_phase(int unsigned budget, bit noisy);
    int unsigned stop_at;
    int unsigned r;
    logic [15:0] magic;
    logic [31:0] len;
    stop_at   = bytes_sent + budget;
    rx_steady = ($urandom_range(0, 3) == 0);
    while (bytes_sent < stop_at) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      r     = $urandom_range(0, 99);
      magic = cur_magic;
      if ($urandom_range(0, 99) < 15) magic = cur_magic ^ 16'($urandom_range(1, 65535));
      len = pick_len(cur_limit);
      if (noisy && r < 8) begin
        repeat ($urandom_range(1, 40)) send_byte(8'($urandom));
        resync();
      end else if (noisy && r < 16) begin
        send_frame(magic, len, $urandom, 16'($urandom), $urandom, $urandom_range(1, 30));
        resync();
      end else begin
        send_frame(magic, len, $urandom, 16'($urandom), $urandom, 0);
      end
    end
    in_valid <= 1'b0;
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    int unsigned gap;
    wait (rst_n);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      gap = rx_steady ? 0 : idle_len();
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: zero-length frame, bad magic (also with a huge length),
    // length over the limit, and a short frame with payload.
    send_frame(16'h0000, 32'd0, '1, '1, '1, 0);
    send_frame(16'hFFFF, 32'd2, '0, '0, '0, 0);
    send_frame(16'h8001, 32'hFFFF_FFFF, 32'h5555_AAAA, 16'hAA55, 32'h0F0F_F0F0, 0);
    send_frame(16'h0000, 32'd65536, '0, '0, '0, 0);
    send_frame(16'h0000, 32'd2, 32'h1234_5678, 16'hA55A, 32'h0BAD_F00D, 0);
    in_valid <= 1'b0;

    set_config(16'hFFFF, 32'd0);
    run_phase(330, 1'b1);
    set_config(16'($urandom), 32'hFFFF_FFFF);
    rx_hold_req = 1'b1;
    run_phase(330, 1'b0);
    set_config(16'($urandom), 32'($urandom_range(1, 48)));
    run_phase(330, 1'b1);
    set_config(16'h0000, 32'd16);
    run_phase(330, 1'b1);
    set_config(16'($urandom), 32'($urandom_range(0, 64)));
    run_phase(330, 1'b1);

    repeat (2) @(posedge clk);
    for (int n = 0; n < 5000 && pending != 0; n++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending != 0) $display("%0t: %0d expected words never arrived", $time, pending);
    if (mismatches == 0 && pending == 0) begin
      $display("frame_header_decoder: match");
    end else begin
      $display("frame_header_decoder: mismatch");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("%0t: timeout", $time);
    $display("frame_header_decoder: mismatch");
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/fhd_pkg.sv
hw/rtl/fhd_parse.sv
hw/rtl/fhd_out_reg.sv
hw/rtl/frame_header_decoder.sv
test/frame_header_decoder_chk.sv
test/frame_header_decoder_tb.sv
